@@ sv/assert_macros.svh @@
// Assertion macros used by the reassembler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed: condition violated");

// Consequence that must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cons)) \
        else $error("assertion failed: next-cycle consequence violated");

`endif

@@ sv/mar_pkg.sv @@
// Types and constants of the metadata access-unit cell reassembler.
package mar_pkg;

    typedef enum logic [1:0] {
        PH_HEADER   = 2'd0,
        PH_STREAM   = 2'd1,
        PH_SKIPCELL = 2'd2,
        PH_SKIPEND  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ABORT = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload;
        logic       unit_end;
        logic       final_of_run;
    } t_result;

    localparam logic [2:0] HC_SERVICE  = 3'd0;
    localparam logic [2:0] HC_SEQUENCE = 3'd1;
    localparam logic [2:0] HC_MODE     = 3'd2;
    localparam logic [2:0] HC_LEN_HIGH = 3'd3;
    localparam logic [2:0] HC_LEN_LOW  = 3'd4;

    localparam logic [15:0] HDR_REST = 16'd4;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = 2;
    localparam int RQ_CW    = 3;

endpackage

@@ sv/metadata_au_cell_reassembler_unit.sv @@
// Metadata access-unit cell reassembler: cell header parser and result queue.
//
// Input channel: one PES payload byte per beat (i_data_byte) with the count
// of payload bytes that follow it in the packet (i_bytes_left, 0 on the last
// byte). A beat is taken when i_in_valid is high and o_in_stall is low.
// Output channel: one result per beat (o_kind, o_payload, o_unit_end,
// o_final_of_run), taken when o_out_valid is high and i_out_stall is low.
// Each input beat yields zero, one or two results; o_final_of_run marks the
// last of them.
// Configuration: i_cfg_data is the service number, written when i_cfg_valid
// is high; o_cfg_ready is always high.
// Results of a beat are written into the result queue and are offered from its head.
// Throughput: one input beat per cycle while o_in_stall is low; the header parse and
// counter update for a beat are combinational from the parser state registers.
// Results wait in a four-entry queue; o_in_stall rises while fewer than two
// entries are free, so a stalled receiver holds the input side back without
// losing results. Reset empties the queue, clears the service number and
// returns the parser to the start of a cell header.
module metadata_au_cell_reassembler_unit
    import mar_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_bytes_left,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload,
    output logic        o_unit_end,
    output logic        o_final_of_run,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

`include "assert_macros.svh"

    t_phase      r_phase, n_phase;
    logic [2:0]  r_header_count, n_header_count;
    logic        r_service_match, n_service_match;
    logic [7:0]  r_cell_sequence, n_cell_sequence;
    logic [1:0]  r_cell_mode, n_cell_mode;
    logic [7:0]  r_length_high, n_length_high;
    logic [15:0] r_payload_left, n_payload_left;
    logic [7:0]  r_last_sequence, n_last_sequence;
    logic        r_unit_pending, n_unit_pending;
    logic [7:0]  r_service_id;

    t_result           r_q [RQ_DEPTH];
    logic [RQ_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [RQ_CW-1:0]  r_count;

    t_result     em [2];
    logic [1:0]  em_cnt;
    logic        in_accept, out_accept;
    logic [15:0] len, pl_dec;
    logic        broken;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_accept  = o_out_valid && !i_out_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_phase         = r_phase;
        n_header_count  = r_header_count;
        n_service_match = r_service_match;
        n_cell_sequence = r_cell_sequence;
        n_cell_mode     = r_cell_mode;
        n_length_high   = r_length_high;
        n_payload_left  = r_payload_left;
        n_last_sequence = r_last_sequence;
        n_unit_pending  = r_unit_pending;
        em[0]  = '{kind: KIND_BYTE, payload: 8'd0, unit_end: 1'b0, final_of_run: 1'b0};
        em[1]  = em[0];
        em_cnt = 2'd0;
        len    = {r_length_high, i_data_byte};
        pl_dec = (r_payload_left != 16'd0) ? r_payload_left - 16'd1 : 16'd0;
        broken = 1'b0;

        unique case (r_phase)
            PH_HEADER: begin
                case (r_header_count)
                    HC_SERVICE: begin
                        if (i_bytes_left < HDR_REST) begin
                            n_phase = PH_SKIPEND;
                        end else begin
                            n_service_match = (i_data_byte == r_service_id);
                            n_header_count  = HC_SEQUENCE;
                        end
                    end
                    HC_SEQUENCE: begin
                        n_cell_sequence = i_data_byte;
                        n_header_count  = HC_MODE;
                    end
                    HC_MODE: begin
                        n_cell_mode    = i_data_byte[7:6];
                        n_header_count = HC_LEN_HIGH;
                    end
                    HC_LEN_HIGH: begin
                        n_length_high  = i_data_byte;
                        n_header_count = HC_LEN_LOW;
                    end
                    default: begin
                        n_header_count = HC_SERVICE;
                        if (i_bytes_left < len) begin
                            n_phase = PH_SKIPEND;
                        end else if (!r_service_match) begin
                            if (len != 16'd0) begin
                                n_payload_left = len;
                                n_phase        = PH_SKIPCELL;
                            end
                        end else begin
                            if (r_cell_mode[1]) begin
                                if (r_unit_pending) begin
                                    em[0].kind = KIND_ABORT;
                                    em_cnt     = 2'd1;
                                end
                                n_unit_pending = 1'b0;
                            end else begin
                                broken = r_unit_pending &&
                                         (r_cell_sequence != 8'(r_last_sequence + 8'd1));
                            end
                            n_last_sequence = r_cell_sequence;
                            if (broken) begin
                                em[0].kind     = KIND_ABORT;
                                em_cnt         = 2'd1;
                                n_unit_pending = 1'b0;
                                if (len != 16'd0) begin
                                    n_payload_left = len;
                                    n_phase        = PH_SKIPCELL;
                                end
                            end else begin
                                n_unit_pending = 1'b1;
                                if (len == 16'd0) begin
                                    if (r_cell_mode[0]) begin
                                        em[em_cnt[0]].kind = KIND_END;
                                        em_cnt             = em_cnt + 2'd1;
                                        n_unit_pending     = 1'b0;
                                    end
                                end else begin
                                    n_payload_left = len;
                                    n_phase        = PH_STREAM;
                                end
                            end
                        end
                    end
                endcase
            end
            PH_STREAM: begin
                n_payload_left   = pl_dec;
                em[0].payload    = i_data_byte;
                em[0].unit_end   = (pl_dec == 16'd0) && r_cell_mode[0];
                em_cnt           = 2'd1;
                if (em[0].unit_end) begin
                    n_unit_pending = 1'b0;
                end
                if (pl_dec == 16'd0) begin
                    n_phase = PH_HEADER;
                end else if (i_bytes_left == 16'd0) begin
                    em[1].kind     = KIND_ABORT;
                    em_cnt         = 2'd2;
                    n_unit_pending = 1'b0;
                    n_payload_left = 16'd0;
                end
            end
            PH_SKIPCELL: begin
                n_payload_left = pl_dec;
                if (pl_dec == 16'd0) begin
                    n_phase = PH_HEADER;
                end
            end
            PH_SKIPEND: begin
            end
        endcase

        if (i_bytes_left == 16'd0) begin
            n_phase        = PH_HEADER;
            n_header_count = HC_SERVICE;
            n_payload_left = 16'd0;
        end
        if (em_cnt == 2'd1) begin
            em[0].final_of_run = 1'b1;
        end
        if (em_cnt == 2'd2) begin
            em[1].final_of_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
        end else if (in_accept) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_count  <= HC_SERVICE;
            r_service_match <= 1'b0;
            r_cell_sequence <= 8'd0;
            r_cell_mode     <= 2'd0;
            r_length_high   <= 8'd0;
            r_payload_left  <= 16'd0;
            r_last_sequence <= 8'd0;
            r_unit_pending  <= 1'b0;
        end else if (in_accept) begin
            r_header_count  <= n_header_count;
            r_service_match <= n_service_match;
            r_cell_sequence <= n_cell_sequence;
            r_cell_mode     <= n_cell_mode;
            r_length_high   <= n_length_high;
            r_payload_left  <= n_payload_left;
            r_last_sequence <= n_last_sequence;
            r_unit_pending  <= n_unit_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_service_id <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_service_id <= i_cfg_data;
        end
    end

    // result queue
    logic [1:0] push;

    assign push = in_accept ? em_cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (push != 2'd0) begin
            r_q[r_wr_ptr] <= em[0];
        end
        if (push == 2'd2) begin
            r_q[RQ_AW'(r_wr_ptr + 1'b1)] <= em[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= RQ_AW'(r_wr_ptr + push);
            if (out_accept) begin
                r_rd_ptr <= RQ_AW'(r_rd_ptr + 1'b1);
            end
            r_count <= RQ_CW'(r_count + RQ_CW'(push) - RQ_CW'(out_accept));
        end
    end

    assign o_in_stall     = (r_count > RQ_CW'(RQ_DEPTH - 2));
    assign o_out_valid    = (r_count != '0);
    assign o_kind         = r_q[r_rd_ptr].kind;
    assign o_payload      = r_q[r_rd_ptr].payload;
    assign o_unit_end     = r_q[r_rd_ptr].unit_end;
    assign o_final_of_run = r_q[r_rd_ptr].final_of_run;

    logic marker_clean, pkt_end_beat, hdr_start;

    assign marker_clean = !(o_out_valid && o_kind != KIND_BYTE) ||
                          (o_payload == 8'd0 && !o_unit_end);
    assign pkt_end_beat = in_accept && (i_bytes_left == 16'd0);
    assign hdr_start    = (r_phase == PH_HEADER) && (r_header_count == HC_SERVICE);

    `ASSERT_ALWAYS(a_queue_bound, i_clk, i_rst_n, r_count <= RQ_CW'(RQ_DEPTH))
    `ASSERT_ALWAYS(a_marker_clean, i_clk, i_rst_n, marker_clean)
    `ASSERT_NEXT(a_packet_restart, i_clk, i_rst_n, pkt_end_beat, hdr_start)

endmodule
